@@ rtl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the threshold pair clustering block
// Command codes, CSR register indices, field widths and the controller state encoding.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int POS_W       = 10;
   localparam int LABEL_W     = 10;
   localparam int SCORE_W     = 24;
   localparam int COUNT_W     = 11;
   localparam int CMD_W       = 2;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [LABEL_W-1:0] LABEL_MAX = 10'd1023;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_SCORE_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITIONS_IN_USE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EVAL  = 5'b00010,
      ST_WRB   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_CLEAR = 5'b10000
   } state_type;

endpackage

@@ rtl/threshold_pair_clustering.sv @@
// ----------------------------------------------------------------------------
// threshold_pair_clustering: threshold single-linkage clustering of positions
// Keeps a cluster label per position in a mirrored pair of label memories.
// ----------------------------------------------------------------------------
// A request carries a command in req_tuser and a position pair with its score
// in req_tdata. Every request gives exactly one response on the rsp_ channel
// with both labels after the step, the stop flag and the unassigned count.
// The csr_ channel writes the score threshold and the number of positions in
// use; it is always ready and is meant to be written only while idle.
// A read, an ignored offer or a join passes through the evaluate state, which
// registers the response once the output register is free and returns to idle.
// Opening a new cluster adds a write-back state, since both labels go through
// the one write port of the label memories. A merge of two clusters is a
// read-modify-write pass over all label entries that follows the response.
// A clear command sweeps zeros through all DEPTH entries of the memories
// before its response, where DEPTH is POSITIONS capped at 1024.
// After reset the same sweep runs, with no response, and req_tready stays low.
// While the receiver stalls, a finished response waits in the output
// register; the next request is still taken, and its own response waits.
// ----------------------------------------------------------------------------
module threshold_pair_clustering #(
   parameter int POSITIONS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_a, pos_b, pair_score, zero fill
   input  logic [tpc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // command
   input  logic [tpc_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // label_a, label_b, stopped, unassigned_left
   output logic [tpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import tpc_pkg::*;

   localparam int DEPTH      = (POSITIONS < 1024) ? POSITIONS : 1024;
   localparam int AW         = $clog2(DEPTH);
   localparam int SIZE_CAP   = (POSITIONS < 2047) ? POSITIONS : 2047;
   localparam int RESET_SIZE = DEPTH;

   state_type                 state_ff, state_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic [POS_W-1:0]          a_ff, a_in, b_ff, b_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [LABEL_W-1:0]        la_ff, la_in, lb_ff, lb_in;
   logic [AW:0]               cnt_ff, cnt_in;
   logic                      reply_ff, reply_in;
   logic                      halted_ff, halted_in;
   logic [LABEL_W-1:0]        next_ff, next_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [SCORE_W-1:0] thr_ff;
   logic [COUNT_W-1:0]        size_cfg_ff;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [LABEL_W-1:0]        wr_data;
   logic [AW-1:0]             rd_addr_a, rd_addr_b;
   logic [LABEL_W-1:0]        rd_a, rd_b;

   logic                      req_accept;
   logic                      rsp_free;
   logic [COUNT_W-1:0]        size_eff;
   logic                      in_a, in_b;
   logic                      issue;
   logic [LABEL_W-1:0]        out_la, out_lb;

   assign size_eff   = (size_cfg_ff > COUNT_W'(SIZE_CAP)) ? COUNT_W'(SIZE_CAP) : size_cfg_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign in_a       = ({1'b0, a_ff} < size_eff);
   assign in_b       = ({1'b0, b_ff} < size_eff);
   assign csr_ready  = 1'b1;

   tpc_ram #(.WIDTH(LABEL_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   tpc_ram #(.WIDTH(LABEL_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   always_comb begin
      rd_addr_a = a_ff[AW-1:0];
      rd_addr_b = b_ff[AW-1:0];
      if (state_ff == ST_IDLE) begin
         rd_addr_a = req_tdata[AW-1:0];
         rd_addr_b = req_tdata[POS_W+AW-1:POS_W];
      end else if (state_ff == ST_SCAN) begin
         rd_addr_a = cnt_ff[AW-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      score_in  = score_ff;
      la_in     = la_ff;
      lb_in     = lb_ff;
      cnt_in    = cnt_ff;
      reply_in  = reply_ff;
      halted_in = halted_ff;
      next_in   = next_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      issue     = 1'b0;
      out_la    = rd_a;
      out_lb    = rd_b;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_tuser;
               a_in     = req_tdata[POS_W-1:0];
               b_in     = req_tdata[2*POS_W-1:POS_W];
               score_in = req_tdata[2*POS_W+SCORE_W-1:2*POS_W];
               if (req_tuser == CMD_CLEAR) begin
                  state_in  = ST_CLEAR;
                  cnt_in    = '0;
                  reply_in  = 1'b1;
                  next_in   = LABEL_W'(1);
                  count_in  = size_eff;
                  halted_in = 1'b0;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (rsp_free) begin
               issue    = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff == CMD_OFFER && !halted_ff) begin
                  if (score_ff <= thr_ff || count_ff == '0) begin
                     halted_in = 1'b1;
                  end else if (in_a && in_b && a_ff != b_ff) begin
                     if (rd_a == '0 && rd_b == '0) begin
                        if (next_ff < LABEL_MAX) begin
                           wr_en    = 1'b1;
                           wr_addr  = a_ff[AW-1:0];
                           wr_data  = next_ff;
                           la_in    = next_ff;
                           out_la   = next_ff;
                           out_lb   = next_ff;
                           next_in  = next_ff + LABEL_W'(1);
                           count_in = (count_ff > COUNT_W'(2)) ? count_ff - COUNT_W'(2) : '0;
                           state_in = ST_WRB;
                        end
                     end else if (rd_b == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = b_ff[AW-1:0];
                        wr_data  = rd_a;
                        out_lb   = rd_a;
                        count_in = (count_ff > COUNT_W'(1)) ? count_ff - COUNT_W'(1) : '0;
                     end else if (rd_a == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = a_ff[AW-1:0];
                        wr_data  = rd_b;
                        out_la   = rd_b;
                        count_in = (count_ff > COUNT_W'(1)) ? count_ff - COUNT_W'(1) : '0;
                     end else if (rd_a != rd_b) begin
                        la_in    = rd_a;
                        lb_in    = rd_b;
                        out_lb   = rd_a;
                        cnt_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
               end
               if (!in_a) begin
                  out_la = '0;
               end
               if (!in_b) begin
                  out_lb = '0;
               end
            end
         end
         ST_WRB: begin
            wr_en    = 1'b1;
            wr_addr  = b_ff[AW-1:0];
            wr_data  = la_ff;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (cnt_ff != '0 && rd_a == lb_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(cnt_ff - (AW+1)'(1));
               wr_data = la_ff;
            end
            if (cnt_ff == (AW+1)'(DEPTH)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            out_la  = '0;
            out_lb  = '0;
            if (cnt_ff[AW-1:0] == AW'(DEPTH - 1)) begin
               if (!reply_ff) begin
                  state_in = ST_IDLE;
               end else if (rsp_free) begin
                  issue    = 1'b1;
                  reply_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (issue) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {count_in, halted_in, out_lb, out_la};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         reply_ff      <= 1'b0;
         halted_ff     <= 1'b0;
         next_ff       <= LABEL_W'(1);
         count_ff      <= COUNT_W'(RESET_SIZE);
         thr_ff        <= '0;
         size_cfg_ff   <= COUNT_W'(1024);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         reply_ff      <= reply_in;
         halted_ff     <= halted_in;
         next_ff       <= next_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_SCORE_THRESHOLD:  thr_ff      <= csr_wdata;
               REG_POSITIONS_IN_USE: size_cfg_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      score_ff     <= score_in;
      la_ff        <= la_in;
      lb_ff        <= lb_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_en)
      else $error("label memory written while idle");

   a_next_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_ff != '0)
      else $error("next cluster label is zero");

   a_halt_from_offer: assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> $past(state_ff == ST_EVAL && cmd_ff == CMD_OFFER))
      else $error("stop flag set outside an offer");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("request accepted without work");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SIZE_CAP))
      else $error("unassigned count above position capacity");

endmodule

@@ rtl/tpc_ram.sv @@
// ----------------------------------------------------------------------------
// tpc_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
